@@ rtl/core/efr_pkg.sv @@
`default_nettype none

package efr_pkg;

  // Byte-stuffed, length-framed receive path: shared types and constants.

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // Payload buffer size; a byte that arrives at or past it aborts the frame.
  localparam logic [7:0] BufSize = 8'd128;

  // Offset of the length byte and the fixed overhead added to it.
  localparam logic [7:0] LenOffset   = 8'd3;
  localparam logic [8:0] LenOverhead = 9'd6;

  // Minimum raw byte count for a timing estimate.
  localparam logic [7:0] MinTimedCount = 8'd8;

  // Register indexes, taken from paddr[2].
  localparam logic RegStartCode  = 1'b0;
  localparam logic RegEscapeCode = 1'b1;

  localparam logic [7:0] StartCodeReset  = 8'd2;
  localparam logic [7:0] EscapeCodeReset = 8'd27;

  typedef enum logic [1:0] {
    FuncByte    = 2'd0,
    FuncPrepare = 2'd1,
    FuncRelease = 2'd2,
    FuncTimeout = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ModeIdle  = 2'd0,
    ModeReady = 2'd1,
    ModeBusy  = 2'd2,
    ModeDone  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic        frame_done;
    logic        frame_abort;
    logic [7:0]  frame_length;
    logic        timing_valid;
    logic [15:0] elapsed_estimate;
    logic [1:0]  receive_state;
    logic        ready_line_high;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] escape_code;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/escaped_frame_receiver.sv @@
// A result passes through the input register and then the result register.
// Throughput: one item per cycle, sustained, as long as the result side takes one per cycle.
// Reset (rst_ni low, asynchronous): receiver idle, counters and previous byte cleared,
// ready line released (high), start code 2, escape code 27, both channels empty.
`default_nettype none

module escaped_frame_receiver (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input channel
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire efr_pkg::in_item_t           in_data_i,
  // Result channel
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      efr_pkg::out_item_t          out_data_o,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [efr_pkg::AddrW-1:0]   paddr,
  input  wire logic [efr_pkg::DataW-1:0]   pwdata,
  output      logic [efr_pkg::DataW-1:0]   prdata,
  output      logic                        pready
);
  import efr_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_q;
  logic      in_valid_q;
  out_item_t out_item_q;
  logic      out_valid_q;
  out_item_t result;
  logic      in_xfer;
  logic      advance;

  // Start and escape codes are held in the register block. They are to be written
  // only while no transfer is in flight; the user must see to it, the block does not enforce it.
  efr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // An item moves from the input register into the result register whenever
  // the result register is empty or is handing its content over this cycle.
  // The frame state advances at that same edge, so every item is processed
  // exactly once, in order.
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_data_i;
    end
  end

  // Decode, frame tracking and the elapsed-time estimate all sit in one
  // short combinational step between the two registers.
  efr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

`default_nettype wire

@@ rtl/core/efr_cfg_regs.sv @@
`default_nettype none

module efr_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [efr_pkg::AddrW-1:0]   paddr,
  input  wire logic [efr_pkg::DataW-1:0]   pwdata,
  output      logic [efr_pkg::DataW-1:0]   prdata,
  output      logic                        pready,
  output      efr_pkg::cfg_t               cfg_o
);
  import efr_pkg::*;

  logic [7:0] start_q;
  logic [7:0] escape_q;
  logic       wr_en;
  logic       reg_sel;

  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= StartCodeReset;
      escape_q <= EscapeCodeReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegStartCode:  start_q  <= pwdata[7:0];
        RegEscapeCode: escape_q <= pwdata[7:0];
        default:       start_q  <= start_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegStartCode:  prdata = {{(DataW-8){1'b0}}, start_q};
      RegEscapeCode: prdata = {{(DataW-8){1'b0}}, escape_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.start_code  = start_q;
  assign cfg_o.escape_code = escape_q;

endmodule

`default_nettype wire

@@ rtl/core/efr_core.sv @@
`default_nettype none

module efr_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire efr_pkg::cfg_t      cfg_i,
  input  wire logic               step_i,
  input  wire efr_pkg::in_item_t  item_i,
  output      efr_pkg::out_item_t result_o
);
  import efr_pkg::*;

  mode_e       mode_q, mode_d;
  logic [7:0]  wpos_q, wpos_d;
  logic [7:0]  raw_q, raw_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  len_q, len_d;
  logic        rline_q, rline_d;

  logic [7:0]  rx_b;
  logic [7:0]  byte_v;
  logic [7:0]  wpos_inc;
  logic [7:0]  raw_inc;
  logic [7:0]  len_eff;
  logic [15:0] est_full;

  logic        dv, done, abort_f, tv;
  logic [7:0]  dbyte, didx;
  logic [15:0] est;

  assign rx_b     = item_i.rx_byte;
  assign byte_v   = (prev_q != cfg_i.escape_code) ? rx_b : ~rx_b;
  assign wpos_inc = wpos_q + 8'd1;
  assign raw_inc  = raw_q + 8'd1;
  assign len_eff  = (wpos_q == LenOffset) ? byte_v : len_q;
  // count*260 + count/2 as shifts and adds, kept modulo 2^16.
  assign est_full = {raw_inc, 8'h00} + 16'({raw_inc, 2'b00}) + 16'(raw_inc[7:1]);

  always_comb begin
    mode_d  = mode_q;
    wpos_d  = wpos_q;
    raw_d   = raw_q;
    prev_d  = prev_q;
    len_d   = len_q;
    rline_d = rline_q;
    dv      = 1'b0;
    dbyte   = '0;
    didx    = '0;
    done    = 1'b0;
    abort_f = 1'b0;
    tv      = 1'b0;
    est     = '0;

    unique case (func_e'(item_i.func))
      FuncByte: begin
        prev_d = rx_b;
        if (rx_b == cfg_i.start_code) begin
          // A start code restarts any frame that is not finished.
          if (mode_q != ModeDone) begin
            wpos_d = '0;
            raw_d  = '0;
            mode_d = ModeBusy;
          end
        end else if (mode_q == ModeBusy) begin
          raw_d   = raw_inc;
          rline_d = 1'b1;
          if (wpos_q >= BufSize) begin
            mode_d  = ModeIdle;
            abort_f = 1'b1;
          end else if (rx_b != cfg_i.escape_code) begin
            dv     = 1'b1;
            dbyte  = byte_v;
            didx   = wpos_q;
            len_d  = len_eff;
            wpos_d = wpos_inc;
            if (wpos_inc > LenOffset &&
                {1'b0, wpos_inc} == ({1'b0, len_eff} + LenOverhead)) begin
              mode_d = ModeDone;
              done   = 1'b1;
              if (raw_inc >= MinTimedCount) begin
                tv  = 1'b1;
                est = est_full;
              end
            end
          end
        end
      end
      FuncPrepare: begin
        if (mode_q != ModeDone) begin
          mode_d  = ModeReady;
          rline_d = 1'b0;
        end
      end
      FuncRelease: begin
        if (mode_q == ModeDone) begin
          mode_d = ModeIdle;
        end
      end
      FuncTimeout: begin
        if (!rline_q) begin
          rline_d = 1'b1;
          mode_d  = ModeIdle;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      wpos_q  <= '0;
      raw_q   <= '0;
      prev_q  <= '0;
      rline_q <= 1'b1;
    end else if (step_i) begin
      mode_q  <= mode_d;
      wpos_q  <= wpos_d;
      raw_q   <= raw_d;
      prev_q  <= prev_d;
      rline_q <= rline_d;
    end
  end

  // The length byte is only read once it has been written in this frame.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      len_q <= len_d;
    end
  end

  always_comb begin
    result_o.data_valid       = dv;
    result_o.data_byte        = dbyte;
    result_o.data_index       = didx;
    result_o.frame_done       = done;
    result_o.frame_abort      = abort_f;
    result_o.frame_length     = wpos_d;
    result_o.timing_valid     = tv;
    result_o.elapsed_estimate = est;
    result_o.receive_state    = mode_d;
    result_o.ready_line_high  = rline_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/efr_checker.sv @@
`default_nettype none

module efr_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  input  wire efr_pkg::out_item_t          out_data_o
);
  import efr_pkg::*;

  // A shown result stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // An overflow stores nothing.
  a_abort_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.data_valid && out_data_o.frame_abort))
    else $error("abort with stored byte");

  // A completed frame stored its last byte and left the receiver complete.
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |->
      out_data_o.data_valid && out_data_o.receive_state == ModeDone)
    else $error("frame done without byte or complete state");

  // A timing estimate only comes with a completed frame.
  a_timing_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.timing_valid |-> out_data_o.frame_done)
    else $error("timing estimate without frame done");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ test/escaped_frame_receiver_test.sv @@
`default_nettype none

module escaped_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import efr_pkg::*;

  // A result passes through the input register and then the result register of the block.
  localparam int ResultLatency = 2;
  // Cycles without any transfer before the run is declared hung.
  localparam int StallLimit = 2000;
  // Weight of one raw byte in the elapsed-time estimate.
  localparam int unsigned ByteWeight = 260;
  // Random input transfers per configuration phase, six phases in all.
  localparam int PhaseItems = 125;
  localparam int NumPhases = 6;

  localparam logic [AddrW-1:0] StartAddr  = {RegStartCode, 2'b00};
  localparam logic [AddrW-1:0] EscapeAddr = {RegEscapeCode, 2'b00};

  // Tracks the decoder state as the block should see it. Each accepted input
  // transfer is decoded into the one result it must produce, and each result
  // transfer is checked against the oldest pending decode.
  class receive_tracker;
    logic [7:0] start_code = StartCodeReset;
    logic [7:0] escape_code = EscapeCodeReset;
    mode_e      mode = ModeIdle;
    logic [7:0] write_pos = '0;
    logic [7:0] raw_count = '0;
    logic [7:0] last_byte = '0;
    logic [7:0] length_byte = '0;
    logic       line_high = 1'b1;
    out_item_t  expected_results[$];
    int         mismatches = 0;

    function out_item_t decode_event(in_item_t item);
      out_item_t   res;
      logic [7:0]  v;
      int unsigned est;
      res = '0;
      case (item.func)
        FuncByte: begin
          if (item.rx_byte == start_code) begin
            // A start code is ignored only while a finished frame waits.
            if (mode != ModeDone) begin
              write_pos = '0;
              raw_count = '0;
              mode = ModeBusy;
            end
          end else if (mode == ModeBusy) begin
            raw_count = raw_count + 8'd1;
            if (write_pos >= BufSize) begin
              mode = ModeIdle;
              res.frame_abort = 1'b1;
            end else if (item.rx_byte != escape_code) begin
              v = (last_byte == escape_code) ? ~item.rx_byte : item.rx_byte;
              res.data_valid = 1'b1;
              res.data_byte = v;
              res.data_index = write_pos;
              if (write_pos == LenOffset) length_byte = v;
              write_pos = write_pos + 8'd1;
              if (write_pos > LenOffset && {1'b0, write_pos} == {1'b0, length_byte} + LenOverhead) begin
                mode = ModeDone;
                res.frame_done = 1'b1;
                if (raw_count >= MinTimedCount) begin
                  est = int'(raw_count) * ByteWeight + int'(raw_count) / 2;
                  res.timing_valid = 1'b1;
                  res.elapsed_estimate = est[15:0];
                end
              end
            end
            line_high = 1'b1;
          end
          last_byte = item.rx_byte;
        end
        FuncPrepare: begin
          if (mode != ModeDone) begin
            mode = ModeReady;
            line_high = 1'b0;
          end
        end
        FuncRelease: begin
          if (mode == ModeDone) mode = ModeIdle;
        end
        default: begin
          if (!line_high) begin
            line_high = 1'b1;
            mode = ModeIdle;
          end
        end
      endcase
      res.frame_length = write_pos;
      res.receive_state = mode;
      res.ready_line_high = line_high;
      return res;
    endfunction

    function void note_transfer(in_item_t item);
      expected_results.push_back(decode_event(item));
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_transfer(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer arrived with no expected result pending");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("data_valid", want.data_valid, got.data_valid);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("data_index", want.data_index, got.data_index);
      compare_field("frame_done", want.frame_done, got.frame_done);
      compare_field("frame_abort", want.frame_abort, got.frame_abort);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("timing_valid", want.timing_valid, got.timing_valid);
      compare_field("elapsed_estimate", want.elapsed_estimate, got.elapsed_estimate);
      compare_field("receive_state", want.receive_state, got.receive_state);
      compare_field("ready_line_high", want.ready_line_high, got.ready_line_high);
    endfunction
  endclass

  // Every input of the block starts at a known value, reset included.
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  in_item_t         in_data = '0;
  logic             out_ready = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;

  logic             in_ready_o;
  logic             out_valid_o;
  out_item_t        out_data_o;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Percentages of cycles in which the sender or the receiver holds off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  receive_tracker tracker = new();

  // Input transfers waiting to be sent, built one frame or burst at a time.
  in_item_t pending[$];

  escaped_frame_receiver u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver takes results at random, at a rate set per phase.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Both channels are observed at the clock edge, where every input of the
  // block still holds the value from before the edge. A transfer on the
  // input side is decoded at once; a transfer on the result side is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) tracker.note_transfer(in_data);
      if (out_valid_o && out_ready) tracker.check_transfer(out_data_o);
    end
  end

  // The run is declared hung once no transfer of either kind has happened
  // for a long stretch of cycles.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  // Offers one input transfer after a random hold-off, and returns at the
  // edge where it is taken. Valid is left high so that the next call can
  // either drop it for a gap or present the next item right away.
  task automatic send_event(in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops offering input and waits until every expected result has come.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // A register write is a setup phase followed by an access phase.
  task automatic write_register(logic [AddrW-1:0] addr, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == StartAddr) begin
      tracker.start_code = value;
    end else begin
      tracker.escape_code = value;
    end
  endtask

  function automatic void add_event(func_e f, logic [7:0] b);
    in_item_t item;
    item.func = f;
    item.rx_byte = b;
    pending.push_back(item);
  endfunction

  // A value can travel stuffed when the escape code is distinct from the
  // start code and its inverse is neither of the two codes.
  function automatic bit stuffable(logic [7:0] v);
    logic [7:0] inv;
    inv = ~v;
    return tracker.escape_code != tracker.start_code &&
           inv != tracker.start_code && inv != tracker.escape_code;
  endfunction

  function automatic logic [7:0] pick_value(logic [7:0] want);
    logic [7:0] v;
    v = want;
    while ((v == tracker.start_code || v == tracker.escape_code) && !stuffable(v)) begin
      v = 8'($urandom);
    end
    return v;
  endfunction

  // Sends a payload value, stuffed when it collides with a code and now and
  // then even when it does not.
  function automatic void add_data(logic [7:0] v);
    if (v == tracker.start_code || v == tracker.escape_code ||
        (stuffable(v) && $urandom_range(9) == 0)) begin
      add_event(FuncByte, tracker.escape_code);
      add_event(FuncByte, ~v);
    end else begin
      add_event(FuncByte, v);
    end
  endfunction

  // Builds one frame. A negative length asks for a random one, mostly short,
  // with a few near the buffer size and a few too long, which overflow. A
  // broken frame is cut off before its last byte.
  function automatic void add_frame(bit broken, int len_choice);
    int         r;
    int         total;
    int         stop;
    logic [7:0] len;
    r = $urandom_range(99);
    if (len_choice >= 0) begin
      len = len_choice[7:0];
    end else if (r < 2) begin
      len = 8'($urandom_range(123, 255));
    end else if (r < 4) begin
      len = 8'($urandom_range(100, 122));
    end else begin
      len = 8'($urandom_range(0, 12));
    end
    len = pick_value(len);
    total = int'(len) + 6;
    if (total > int'(BufSize) + 1) total = int'(BufSize) + 1;
    stop = broken ? $urandom_range(1, total - 1) : total;
    if ($urandom_range(1) == 1) add_event(FuncPrepare, 8'($urandom));
    add_event(FuncByte, tracker.start_code);
    for (int i = 0; i < stop; i++) begin
      if (i == int'(LenOffset)) begin
        add_data(len);
      end else begin
        add_data(pick_value(8'($urandom)));
      end
    end
    if (!broken) begin
      r = $urandom_range(99);
      if (r < 75) begin
        add_event(FuncRelease, 8'($urandom));
      end else if (r < 85) begin
        add_event(FuncTimeout, 8'($urandom));
      end else if (r < 92) begin
        add_event(FuncPrepare, 8'($urandom));
      end
    end
  endfunction

  // A short burst of arbitrary events, with codes turning up often.
  function automatic void add_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: b = tracker.start_code;
        1, 2: b = tracker.escape_code;
        default: b = 8'($urandom);
      endcase
      add_event(func_e'($urandom_range(3)), b);
    end
  endfunction

  initial begin : stimulus
    int         sent;
    int         r;
    bit         drained;
    logic [7:0] start_val;
    logic [7:0] escape_val;

    send_idle_pct = 21;
    recv_idle_pct = 77;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events with the codes left at their reset values.
    pending.delete();
    add_event(FuncTimeout, 8'hA5);   // Timeout with the line released: ignored.
    add_event(FuncRelease, 8'h00);   // Release with no finished frame: ignored.
    add_event(FuncPrepare, 8'hFF);
    add_event(FuncTimeout, 8'h00);   // Timeout with the line asserted: back to idle.
    add_event(FuncPrepare, 8'h00);
    add_event(FuncByte, 8'h55);      // Plain byte outside a frame.
    add_event(FuncByte, StartCodeReset);
    add_event(FuncByte, 8'h00);
    add_event(FuncByte, 8'hFF);
    add_event(FuncByte, EscapeCodeReset);
    add_event(FuncByte, 8'hFD);      // Stored inverted, which is the start code.
    add_event(FuncByte, EscapeCodeReset);
    add_event(FuncByte, 8'hFF);      // Length byte zero, stuffed.
    add_event(FuncByte, 8'h80);
    add_event(FuncByte, 8'h7F);      // Completes the frame with a timing estimate.
    add_event(FuncByte, StartCodeReset);  // Start code with a frame pending: ignored.
    add_event(FuncPrepare, 8'h00);   // Prepare with a frame pending: ignored.
    add_event(FuncRelease, 8'h00);
    add_event(FuncByte, StartCodeReset);
    add_event(FuncByte, 8'h33);
    add_event(FuncByte, StartCodeReset);  // Start code inside a frame restarts it.
    add_event(FuncByte, 8'h44);
    foreach (pending[i]) send_event(pending[i]);

    for (int phase = 0; phase < NumPhases; phase++) begin
      // Registers change only with the block idle.
      wait_for_results();
      repeat (ResultLatency) @(posedge clk_i);
      case (phase)
        0: begin
          start_val = StartCodeReset;
          escape_val = EscapeCodeReset;
        end
        1: begin
          start_val = 8'h00;
          escape_val = 8'hFF;
        end
        2: begin
          start_val = 8'hFF;
          escape_val = 8'h00;
        end
        3: begin
          start_val = 8'h7E;
          escape_val = 8'h7D;
        end
        4: begin
          // Equal codes: the start meaning has to win.
          start_val = 8'h55;
          escape_val = 8'h55;
        end
        default: begin
          start_val = 8'($urandom);
          escape_val = 8'($urandom);
        end
      endcase
      write_register(StartAddr, start_val);
      write_register(EscapeAddr, escape_val);
      @(posedge clk_i);

      if (phase < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 77;
      end else if (phase < 4) begin
        send_idle_pct = 77;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      sent = 0;
      drained = 1'b0;
      while (sent < PhaseItems) begin
        pending.delete();
        r = $urandom_range(99);
        if (sent == 0 && phase == 0) begin
          add_frame(1'b0, 255);        // Overflow of the buffer.
        end else if (sent == 0 && phase == 3) begin
          add_frame(1'b0, int'(BufSize) - 6);  // Frame that fills the buffer.
        end else if (r < 70) begin
          add_frame(1'b0, -1);
        end else if (r < 85) begin
          add_frame(1'b1, -1);
        end else begin
          add_noise();
        end
        sent += pending.size();
        foreach (pending[i]) send_event(pending[i]);
        // Midway through each phase the sender waits for the block to drain.
        if (!drained && sent >= PhaseItems / 2) begin
          wait_for_results();
          drained = 1'b1;
        end
      end
    end

    wait_for_results();
    repeat (4 * ResultLatency) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
